// ===== rtl/scs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_pkg
// shared types, codes and limits of the smtp client sequencer
// ----------------------------------------------------------------------------
package scs_pkg;

  // longest reply, in bytes, before the exchange is cut off
  localparam int MAX_REPLY_BYTES = 8192;
  // reply byte counter width covers the incremented count, up to MAX_REPLY_BYTES + 1
  localparam int LEN_W = $clog2(MAX_REPLY_BYTES + 2);

  localparam int CODE_W = 10;

  // expected reply codes
  localparam logic [CODE_W-1:0] CODE_READY      = 10'd220;
  localparam logic [CODE_W-1:0] CODE_OK         = 10'd250;
  localparam logic [CODE_W-1:0] CODE_FORWARD    = 10'd251;
  localparam logic [CODE_W-1:0] CODE_AUTH_CONT  = 10'd334;
  localparam logic [CODE_W-1:0] CODE_AUTH_OK    = 10'd235;
  localparam logic [CODE_W-1:0] CODE_DATA_START = 10'd354;

  // configuration register indexes
  localparam logic [1:0] CFG_SECURITY_MODE       = 2'd0;
  localparam logic [1:0] CFG_AUTH_MODE           = 2'd1;
  localparam logic [1:0] CFG_CREDENTIALS_PRESENT = 2'd2;
  localparam logic [1:0] CFG_UPGRADE_AVAILABLE   = 2'd3;

  // register value codes
  localparam logic [1:0] SEC_STARTTLS = 2'd1;
  localparam logic [1:0] AUTH_NONE    = 2'd0;
  localparam logic [1:0] AUTH_LOGIN   = 2'd1;

  typedef enum logic [2:0] {
    ACT_START     = 3'd0,
    ACT_BYTE      = 3'd1,
    ACT_CLOSE     = 3'd2,
    ACT_UP_DONE   = 3'd3,
    ACT_UP_FAILED = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_EHLO       = 4'd1,
    CMD_STARTTLS   = 4'd2,
    CMD_BEGIN_TLS  = 4'd3,
    CMD_AUTH_LOGIN = 4'd4,
    CMD_USER       = 4'd5,
    CMD_PASS       = 4'd6,
    CMD_AUTH_PLAIN = 4'd7,
    CMD_MAIL       = 4'd8,
    CMD_RCPT       = 4'd9,
    CMD_DATA       = 4'd10,
    CMD_BODY       = 4'd11,
    CMD_QUIT       = 4'd12
  } cmd_t;

  typedef enum logic [2:0] {
    ST_RUNNING        = 3'd0,
    ST_DONE           = 3'd1,
    ST_REFUSED        = 3'd2,
    ST_CLOSED         = 3'd3,
    ST_TOO_LONG       = 3'd4,
    ST_NO_CREDENTIALS = 3'd5,
    ST_NO_UPGRADE     = 3'd6,
    ST_UPGRADE_FAILED = 3'd7
  } stat_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_GREET    = 4'd1,
    PH_EHLO1    = 4'd2,
    PH_STLS     = 4'd3,
    PH_UPGRADE  = 4'd4,
    PH_EHLO2    = 4'd5,
    PH_ALOGIN   = 4'd6,
    PH_AUSER    = 4'd7,
    PH_APASS    = 4'd8,
    PH_APLAIN   = 4'd9,
    PH_MAIL     = 4'd10,
    PH_RCPT     = 4'd11,
    PH_DATA     = 4'd12,
    PH_BODY     = 4'd13,
    PH_QUIT     = 4'd14,
    PH_FINISHED = 4'd15
  } phase_t;

  typedef struct packed {
    logic [1:0] security_mode;
    logic [1:0] auth_mode;
    logic       credentials_present;
    logic       upgrade_available;
  } cfg_t;

  // phase controller to line scanner
  typedef struct packed {
    logic byte_en;
    logic restart;
  } scan_ctl_t;

  // line scanner to phase controller
  typedef struct packed {
    logic              complete;
    logic              too_long;
    logic [CODE_W-1:0] code;
  } scan_evt_t;

  typedef struct packed {
    logic              valid;
    cmd_t              command;
    stat_t             status;
    logic [CODE_W-1:0] code;
  } result_t;

endpackage

// ===== rtl/scs_line_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_line_scanner
// tracks the current reply line and reply length, flags a final line or an overlong reply
// ----------------------------------------------------------------------------
module scs_line_scanner (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  input  scs_pkg::scan_ctl_t    ctl,
  output scs_pkg::scan_evt_t    evt
);
  import scs_pkg::*;

  logic [2:0]        line_pos;
  logic [CODE_W-1:0] code_acc;
  logic              digits_ok;
  logic              space4;
  logic [LEN_W-1:0]  reply_len;

  logic [2:0]        line_pos_next;
  logic [CODE_W-1:0] code_acc_next;
  logic              digits_ok_next;
  logic              space4_next;
  logic [LEN_W-1:0]  reply_len_next;

  logic [LEN_W-1:0]  len_inc;
  logic [13:0]       acc_sum;
  logic              is_lf;

  always_comb begin
    len_inc  = reply_len + LEN_W'(1);
    is_lf    = (rx_byte == 8'h0A);
    acc_sum  = (14'(code_acc) << 3) + (14'(code_acc) << 1) + 14'(rx_byte - 8'h30);

    evt.complete = is_lf && digits_ok && space4 && (line_pos == 3'd4);
    evt.code     = code_acc;
    evt.too_long = !evt.complete && (len_inc > LEN_W'(MAX_REPLY_BYTES));

    line_pos_next  = line_pos;
    code_acc_next  = code_acc;
    digits_ok_next = digits_ok;
    space4_next    = space4;
    reply_len_next = reply_len;

    if (ctl.restart) begin
      line_pos_next  = '0;
      code_acc_next  = '0;
      digits_ok_next = 1'b1;
      space4_next    = 1'b0;
      reply_len_next = '0;
    end else if (ctl.byte_en) begin
      reply_len_next = evt.complete ? '0 : len_inc;
      if (is_lf) begin
        line_pos_next  = '0;
        code_acc_next  = '0;
        digits_ok_next = 1'b1;
        space4_next    = 1'b0;
      end else begin
        if (line_pos < 3'd3) begin
          if (rx_byte inside {[8'h30:8'h39]}) begin
            code_acc_next = acc_sum[CODE_W-1:0];
          end else begin
            digits_ok_next = 1'b0;
          end
        end else if (line_pos == 3'd3) begin
          space4_next = (rx_byte == 8'h20);
        end
        if (line_pos < 3'd4) begin
          line_pos_next = line_pos + 3'd1;
        end
      end
      // overlong reply drops everything gathered so far
      if (evt.too_long) begin
        reply_len_next = '0;
        line_pos_next  = '0;
        code_acc_next  = '0;
        digits_ok_next = 1'b1;
        space4_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos  <= '0;
      code_acc  <= '0;
      digits_ok <= 1'b1;
      space4    <= 1'b0;
      reply_len <= '0;
    end else if (advance) begin
      line_pos  <= line_pos_next;
      code_acc  <= code_acc_next;
      digits_ok <= digits_ok_next;
      space4    <= space4_next;
      reply_len <= reply_len_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    line_pos <= 3'd4)
    else $error("line position beyond fourth byte");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    reply_len <= LEN_W'(MAX_REPLY_BYTES))
    else $error("reply length kept above limit");

endmodule

// ===== rtl/scs_phase_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scs_phase_ctrl
// exchange phase state machine, checks reply codes and picks the next command
// ----------------------------------------------------------------------------
module scs_phase_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [2:0]          action,
  input  scs_pkg::cfg_t       cfg,
  input  scs_pkg::scan_evt_t  evt,
  output scs_pkg::scan_ctl_t  ctl,
  output scs_pkg::result_t    result
);
  import scs_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic              running;
  logic [CODE_W-1:0] want;
  logic              code_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    running = (phase != PH_IDLE) && (phase != PH_FINISHED);

    case (phase)
      PH_GREET, PH_STLS:   want = CODE_READY;
      PH_ALOGIN, PH_AUSER: want = CODE_AUTH_CONT;
      PH_APASS, PH_APLAIN: want = CODE_AUTH_OK;
      PH_DATA:             want = CODE_DATA_START;
      default:             want = CODE_OK;
    endcase
    code_ok = (phase == PH_RCPT) ? (evt.code == CODE_OK || evt.code == CODE_FORWARD)
                                 : (evt.code == want);

    phase_next     = phase;
    ctl            = '0;
    result.valid   = 1'b0;
    result.command = CMD_NONE;
    result.status  = ST_RUNNING;
    result.code    = '0;

    case (action_t'(action))
      ACT_START: begin
        phase_next  = PH_GREET;
        ctl.restart = 1'b1;
      end
      ACT_BYTE: begin
        if (running && phase != PH_UPGRADE) begin
          ctl.byte_en = 1'b1;
          if (evt.complete) begin
            result.valid = 1'b1;
            result.code  = evt.code;
            if (phase == PH_QUIT) begin
              result.status = ST_DONE;
            end else if (!code_ok) begin
              result.status = ST_REFUSED;
            end else begin
              case (phase)
                PH_GREET: begin
                  phase_next     = PH_EHLO1;
                  result.command = CMD_EHLO;
                end
                PH_EHLO1, PH_EHLO2: begin
                  if (phase == PH_EHLO1 && cfg.security_mode == SEC_STARTTLS) begin
                    phase_next     = PH_STLS;
                    result.command = CMD_STARTTLS;
                  end else if (cfg.auth_mode == AUTH_NONE) begin
                    phase_next     = PH_MAIL;
                    result.command = CMD_MAIL;
                  end else if (!cfg.credentials_present) begin
                    result.status = ST_NO_CREDENTIALS;
                  end else if (cfg.auth_mode == AUTH_LOGIN) begin
                    phase_next     = PH_ALOGIN;
                    result.command = CMD_AUTH_LOGIN;
                  end else begin
                    phase_next     = PH_APLAIN;
                    result.command = CMD_AUTH_PLAIN;
                  end
                end
                PH_STLS: begin
                  if (!cfg.upgrade_available) begin
                    result.status = ST_NO_UPGRADE;
                  end else begin
                    phase_next     = PH_UPGRADE;
                    result.command = CMD_BEGIN_TLS;
                  end
                end
                PH_ALOGIN: begin
                  phase_next     = PH_AUSER;
                  result.command = CMD_USER;
                end
                PH_AUSER: begin
                  phase_next     = PH_APASS;
                  result.command = CMD_PASS;
                end
                PH_APASS, PH_APLAIN: begin
                  phase_next     = PH_MAIL;
                  result.command = CMD_MAIL;
                end
                PH_MAIL: begin
                  phase_next     = PH_RCPT;
                  result.command = CMD_RCPT;
                end
                PH_RCPT: begin
                  phase_next     = PH_DATA;
                  result.command = CMD_DATA;
                end
                PH_DATA: begin
                  phase_next     = PH_BODY;
                  result.command = CMD_BODY;
                end
                default: begin
                  phase_next     = PH_QUIT;
                  result.command = CMD_QUIT;
                end
              endcase
            end
          end else if (evt.too_long) begin
            result.valid  = 1'b1;
            result.status = (phase == PH_QUIT) ? ST_DONE : ST_TOO_LONG;
          end
        end
      end
      ACT_CLOSE: begin
        if (running) begin
          result.valid  = 1'b1;
          result.status = (phase == PH_QUIT) ? ST_DONE : ST_CLOSED;
        end
      end
      ACT_UP_DONE: begin
        if (phase == PH_UPGRADE) begin
          phase_next     = PH_EHLO2;
          ctl.restart    = 1'b1;
          result.valid   = 1'b1;
          result.command = CMD_EHLO;
        end
      end
      ACT_UP_FAILED: begin
        if (phase == PH_UPGRADE) begin
          result.valid  = 1'b1;
          result.status = ST_UPGRADE_FAILED;
        end
      end
      default: begin
      end
    endcase

    if (result.valid && result.status != ST_RUNNING) begin
      phase_next = PH_FINISHED;
    end
  end

  a_end_finishes: assert property (@(posedge clk) disable iff (rst)
    advance && result.valid && result.status != ST_RUNNING |=> phase == PH_FINISHED)
    else $error("terminal status did not finish the exchange");

  a_end_no_cmd: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_RUNNING |-> result.command == CMD_NONE)
    else $error("command issued together with a terminal status");

endmodule

// ===== rtl/smtp_client_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smtp_client_sequencer
// smtp submission client sequencer: reply parsing and command selection
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  --------------------------------
//  input     in         in_valid / in_ready    action, rx_byte
//  output    out        out_valid / out_ready  command, status, reply_code
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  a request sits in the input register while the scanner and phase
//  logic resolve it; its result goes to the result register once that register can take it
//  sustained rate is one request per cycle while out_ready stays high
//  a request that gives no result still waits only on the result register
//  reset (synchronous) returns the phase to idle and clears the line state,
//  config returns to its defaults; cfg_ready is always high
//  a stalled result holds the result register, and the input register then
//  holds one more request before in_ready drops
//
module smtp_client_sequencer (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [7:0] rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] command,
  output logic [2:0] status,
  output logic [9:0] reply_code,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);
  import scs_pkg::*;

  // configuration registers
  cfg_t cfg;

  // input register
  logic       ireg_valid;
  logic [2:0] ireg_action;
  logic [7:0] ireg_byte;

  // result register
  cmd_t              out_command;
  stat_t             out_status;
  logic [CODE_W-1:0] res_code;

  logic      advance;
  scan_ctl_t scan_ctl;
  scan_evt_t scan_evt;
  result_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.security_mode       <= 2'd0;
      cfg.auth_mode           <= AUTH_NONE;
      cfg.credentials_present <= 1'b0;
      cfg.upgrade_available   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SECURITY_MODE:       cfg.security_mode       <= cfg_data;
        CFG_AUTH_MODE:           cfg.auth_mode           <= cfg_data;
        CFG_CREDENTIALS_PRESENT: cfg.credentials_present <= cfg_data[0];
        CFG_UPGRADE_AVAILABLE:   cfg.upgrade_available   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // the held request moves on once the result register can take its result
  assign advance  = ireg_valid && (!out_valid || out_ready);
  assign in_ready = !ireg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_action <= action;
      ireg_byte   <= rx_byte;
    end
  end

  scs_line_scanner u_scanner (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (ireg_byte),
    .ctl     (scan_ctl),
    .evt     (scan_evt)
  );

  scs_phase_ctrl u_phase (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .action  (ireg_action),
    .cfg     (cfg),
    .evt     (scan_evt),
    .ctl     (scan_ctl),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_command <= result.command;
      out_status  <= result.status;
      res_code    <= result.code;
    end
  end

  assign command    = out_command;
  assign status     = out_status;
  assign reply_code = res_code;

  // backpressure only comes from a full input register behind a stalled result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ireg_valid && out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // a request with a result always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && result.valid |=> out_valid)
    else $error("result lost on its way to the output");

endmodule

// ===== bench/tb_smtp_client_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smtp_client_sequencer
// self-checking bench for the smtp client sequencer: events and server reply
// bytes are sent under random flow control on both channels, a local copy of
// the submission exchange works out each command or status, and every result
// is compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb_smtp_client_sequencer;
  import scs_pkg::*;

  localparam int RANDOM_REQUESTS = 1850;
  // longest legal stretch with no handshake is the long receiver stall
  localparam int QUIET_LIMIT     = 2000;
  // result register plus input register, with margin
  localparam int DRAIN_CYCLES    = 4;
  localparam int LONG_STALL      = 300;
  // line every so often inside padding, never a valid reply line
  localparam int PAD_LINE        = 40;

  // register values that the package leaves unnamed
  localparam logic [1:0] SEC_PLAIN  = 2'd0;
  localparam logic [1:0] SEC_OTHER  = 2'd2;
  localparam logic [1:0] SEC_SPARE  = 2'd3;
  localparam logic [1:0] AUTH_PLAIN = 2'd2;
  localparam logic [1:0] AUTH_SPARE = 2'd3;

  localparam logic [7:0] LF    = 8'h0A;
  localparam logic [7:0] CR    = 8'h0D;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] DASH  = 8'h2D;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] action;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] command;
  logic [2:0] status;
  logic [9:0] reply_code;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [1:0] cfg_data;

  smtp_client_sequencer uut (.*);

  typedef struct {
    cmd_t       cmd;
    stat_t      stat;
    logic [9:0] code;
  } outcome_t;

  typedef logic [7:0] octets_t[$];

  // local copy of the exchange: settings, phase and reply scanner
  cfg_t        cfg_m;
  phase_t      ph;
  logic [2:0]  line_pos;
  logic [9:0]  code_acc;
  logic        digits_ok;
  logic        space_seen;
  int unsigned reply_len;

  // commands and statuses still owed by the block, oldest first
  outcome_t outcomes_due[$];

  int errors;
  int sent;
  int quiet;
  int stall_cycles;
  bit tx_gaps_on;
  bit rx_gaps_on;

  // --------------------------------------------------------------------------
  // exchange tracking
  // --------------------------------------------------------------------------

  function automatic void restart_line();
    line_pos   = '0;
    code_acc   = '0;
    digits_ok  = 1'b1;
    space_seen = 1'b0;
  endfunction

  // any status other than running closes the exchange
  function automatic outcome_t conclude(cmd_t c, stat_t s, logic [9:0] code);
    outcome_t o;
    o.cmd  = c;
    o.stat = s;
    o.code = code;
    if (s != ST_RUNNING) ph = PH_FINISHED;
    return o;
  endfunction

  // 250 to the last EHLO: go to auth or straight to MAIL, or stop without credentials
  function automatic outcome_t after_hello(logic [9:0] code);
    if (cfg_m.auth_mode == AUTH_NONE) begin
      ph = PH_MAIL;
      return conclude(CMD_MAIL, ST_RUNNING, code);
    end
    if (!cfg_m.credentials_present) return conclude(CMD_NONE, ST_NO_CREDENTIALS, code);
    if (cfg_m.auth_mode == AUTH_LOGIN) begin
      ph = PH_ALOGIN;
      return conclude(CMD_AUTH_LOGIN, ST_RUNNING, code);
    end
    ph = PH_APLAIN;
    return conclude(CMD_AUTH_PLAIN, ST_RUNNING, code);
  endfunction

  function automatic logic [9:0] code_wanted(phase_t p);
    case (p)
      PH_GREET, PH_STLS:   return CODE_READY;
      PH_ALOGIN, PH_AUSER: return CODE_AUTH_CONT;
      PH_APASS, PH_APLAIN: return CODE_AUTH_OK;
      PH_DATA:             return CODE_DATA_START;
      default:             return CODE_OK;
    endcase
  endfunction

  function automatic outcome_t judge_reply(logic [9:0] code);
    bit ok;
    // whatever the server says to QUIT ends the exchange cleanly
    if (ph == PH_QUIT) return conclude(CMD_NONE, ST_DONE, code);
    if (ph == PH_RCPT) ok = (code == CODE_OK) || (code == CODE_FORWARD);
    else ok = (code == code_wanted(ph));
    if (!ok) return conclude(CMD_NONE, ST_REFUSED, code);
    case (ph)
      PH_GREET: begin
        ph = PH_EHLO1;
        return conclude(CMD_EHLO, ST_RUNNING, code);
      end
      PH_EHLO1: begin
        if (cfg_m.security_mode == SEC_STARTTLS) begin
          ph = PH_STLS;
          return conclude(CMD_STARTTLS, ST_RUNNING, code);
        end
        return after_hello(code);
      end
      PH_STLS: begin
        if (!cfg_m.upgrade_available) return conclude(CMD_NONE, ST_NO_UPGRADE, code);
        ph = PH_UPGRADE;
        return conclude(CMD_BEGIN_TLS, ST_RUNNING, code);
      end
      PH_EHLO2: return after_hello(code);
      PH_ALOGIN: begin
        ph = PH_AUSER;
        return conclude(CMD_USER, ST_RUNNING, code);
      end
      PH_AUSER: begin
        ph = PH_APASS;
        return conclude(CMD_PASS, ST_RUNNING, code);
      end
      PH_APASS, PH_APLAIN: begin
        ph = PH_MAIL;
        return conclude(CMD_MAIL, ST_RUNNING, code);
      end
      PH_MAIL: begin
        ph = PH_RCPT;
        return conclude(CMD_RCPT, ST_RUNNING, code);
      end
      PH_RCPT: begin
        ph = PH_DATA;
        return conclude(CMD_DATA, ST_RUNNING, code);
      end
      PH_DATA: begin
        ph = PH_BODY;
        return conclude(CMD_BODY, ST_RUNNING, code);
      end
      default: begin
        ph = PH_QUIT;
        return conclude(CMD_QUIT, ST_RUNNING, code);
      end
    endcase
  endfunction

  function automatic bit take_byte(logic [7:0] b, output outcome_t o);
    bit         complete;
    logic [9:0] code;
    reply_len++;
    if (b == LF) begin
      complete = digits_ok && space_seen && (line_pos >= 3'd4);
      code = code_acc;
      restart_line();
      // a completing line is judged before the length limit
      if (complete) begin
        reply_len = 0;
        o = judge_reply(code);
        return 1'b1;
      end
    end else begin
      if (line_pos < 3'd3) begin
        if (b >= 8'h30 && b <= 8'h39) code_acc = 10'(code_acc * 10 + (b - 8'h30));
        else digits_ok = 1'b0;
      end else if (line_pos == 3'd3) begin
        space_seen = (b == SPACE);
      end
      if (line_pos < 3'd4) line_pos++;
    end
    if (reply_len > MAX_REPLY_BYTES) begin
      reply_len = 0;
      restart_line();
      if (ph == PH_QUIT) o = conclude(CMD_NONE, ST_DONE, '0);
      else o = conclude(CMD_NONE, ST_TOO_LONG, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one accepted request: returns 1 when it owes a result
  function automatic bit advance_exchange(logic [2:0] act, logic [7:0] b,
                                          output outcome_t o);
    bit running;
    running = (ph != PH_IDLE) && (ph != PH_FINISHED);
    case (act)
      ACT_START: begin
        ph = PH_GREET;
        restart_line();
        reply_len = 0;
        return 1'b0;
      end
      ACT_BYTE: begin
        if (!running || ph == PH_UPGRADE) return 1'b0;
        return take_byte(b, o);
      end
      ACT_CLOSE: begin
        if (!running) return 1'b0;
        if (ph == PH_QUIT) o = conclude(CMD_NONE, ST_DONE, '0);
        else o = conclude(CMD_NONE, ST_CLOSED, '0);
        return 1'b1;
      end
      ACT_UP_DONE: begin
        if (ph != PH_UPGRADE) return 1'b0;
        ph = PH_EHLO2;
        restart_line();
        reply_len = 0;
        o = conclude(CMD_EHLO, ST_RUNNING, '0);
        return 1'b1;
      end
      ACT_UP_FAILED: begin
        if (ph != PH_UPGRADE) return 1'b0;
        o = conclude(CMD_NONE, ST_UPGRADE_FAILED, '0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // valid stays up after acceptance; the next request or drain_results
  // decides at the following falling edge whether it drops
  task automatic send_req(logic [2:0] act, logic [7:0] b);
    int       gap;
    outcome_t o;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    if (advance_exchange(act, b, o)) outcomes_due.push_back(o);
    sent++;
  endtask

  // stop offering, wait for every owed result, then let the pipe empty
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SECURITY_MODE:       cfg_m.security_mode       = val;
      CFG_AUTH_MODE:           cfg_m.auth_mode           = val;
      CFG_CREDENTIALS_PRESENT: cfg_m.credentials_present = val[0];
      default:                 cfg_m.upgrade_available   = val[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // only written with the block idle; unused upper bit of the flags is random
  task automatic configure(logic [1:0] sec, logic [1:0] auth, bit cred, bit up);
    drain_results();
    write_reg(CFG_SECURITY_MODE, sec);
    write_reg(CFG_AUTH_MODE, auth);
    write_reg(CFG_CREDENTIALS_PRESENT, {1'($urandom_range(0, 1)), cred});
    write_reg(CFG_UPGRADE_AVAILABLE, {1'($urandom_range(0, 1)), up});
  endtask

  function automatic void push_code(ref octets_t q, input int c);
    q.push_back(8'(48 + c / 100));
    q.push_back(8'(48 + (c / 10) % 10));
    q.push_back(8'(48 + c % 10));
  endfunction

  // any byte but a line feed
  function automatic void push_text(ref octets_t q, input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == LF) b = 8'h0B;
      q.push_back(b);
    end
  endfunction

  // one server reply; a messy one is led by lines that never complete it
  task automatic send_reply(int code, bit messy);
    octets_t    q;
    int         kind;
    logic [7:0] b;
    if (messy) begin
      repeat ($urandom_range(1, 2)) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: begin
            // continuation line of a multi-line reply
            push_code(q, $urandom_range(0, 999));
            q.push_back(DASH);
            push_text(q, $urandom_range(0, 3));
          end
          1: begin
            // junk line that does not start with a digit
            b = 8'($urandom_range(0, 255));
            if (b >= 8'h30 && b <= 8'h39) b = 8'h41;
            q.push_back(b);
            push_text(q, $urandom_range(0, 5));
          end
          2: begin
            // line too short to carry a code
            push_code(q, $urandom_range(0, 999));
            void'(q.pop_back());
          end
          default: begin
            // right code but no space after it
            push_code(q, code);
            q.push_back(CR);
          end
        endcase
        if ($urandom_range(0, 1)) q.push_back(CR);
        q.push_back(LF);
      end
    end
    push_code(q, code);
    q.push_back(SPACE);
    push_text(q, $urandom_range(0, 3));
    if ($urandom_range(0, 1)) q.push_back(CR);
    q.push_back(LF);
    foreach (q[i]) send_req(ACT_BYTE, q[i]);
  endtask

  // bytes that never form a reply line; always ends on a line feed
  task automatic send_padding(int n);
    for (int i = 0; i < n; i++) begin
      if (i % PAD_LINE == PAD_LINE - 1 || i == n - 1) send_req(ACT_BYTE, LF);
      else send_req(ACT_BYTE, 8'(8'h61 + i % 26));
    end
  endtask

  // a code the current phase accepts
  function automatic int fitting_code();
    if (ph == PH_RCPT) return $urandom_range(0, 1) ? CODE_FORWARD : CODE_OK;
    if (ph == PH_QUIT) return $urandom_range(0, 999);
    return code_wanted(ph);
  endfunction

  // mostly a well-formed exchange, with wrong codes, closes, restarts and
  // stray events mixed in
  task automatic run_exchange();
    int r;
    send_req(ACT_START, 8'($urandom_range(0, 255)));
    while (ph != PH_IDLE && ph != PH_FINISHED) begin
      r = $urandom_range(0, 99);
      if (ph == PH_UPGRADE) begin
        if (r < 80) send_req(ACT_UP_DONE, 8'($urandom_range(0, 255)));
        else if (r < 88) send_req(ACT_UP_FAILED, 8'($urandom_range(0, 255)));
        else if (r < 94) send_req(ACT_BYTE, 8'($urandom_range(0, 255)));
        else send_req(ACT_CLOSE, 8'($urandom_range(0, 255)));
      end else if (r < 84) begin
        send_reply(fitting_code(), $urandom_range(0, 3) == 0);
      end else if (r < 90) begin
        send_reply($urandom_range(0, 999), 1'b1);
      end else if (r < 93) begin
        send_req(ACT_CLOSE, 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_req(ACT_START, 8'($urandom_range(0, 255)));
      end else if (r < 97) begin
        // upgrade events out of place and unused actions
        send_req(3'($urandom_range(3, 7)), 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_req(ACT_BYTE, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // events with no exchange running, close, refusal and code extremes
  task automatic test_directed_events();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    // idle: everything is dropped
    send_req(ACT_BYTE, 8'h00);
    send_req(ACT_CLOSE, 8'hFF);
    send_req(ACT_UP_DONE, 8'h00);
    send_req(ACT_UP_FAILED, 8'hFF);
    for (int a = 5; a < 8; a++) send_req(3'(a), 8'hFF);
    // greeting, then the link drops
    send_req(ACT_START, 8'hFF);
    send_reply(CODE_READY, 1'b0);
    send_req(ACT_CLOSE, 8'h00);
    // finished: dropped as well
    send_req(ACT_CLOSE, 8'h00);
    send_req(ACT_BYTE, 8'hFF);
    // highest and lowest codes are refused
    send_req(ACT_START, 8'h00);
    send_reply(999, 1'b0);
    send_req(ACT_START, 8'h00);
    send_reply(0, 1'b0);
  endtask

  // reply byte limit: completing on byte MAX_REPLY_BYTES + 1, one over, and one over in QUIT
  task automatic test_reply_limit();
    octets_t greet;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    configure(SEC_PLAIN, AUTH_NONE, 1'b0, 1'b1);
    send_req(ACT_START, 8'h00);
    // the closing line feed is byte MAX_REPLY_BYTES + 1 and still completes
    send_padding(MAX_REPLY_BYTES - 4);
    push_code(greet, CODE_READY);
    greet.push_back(SPACE);
    greet.push_back(LF);
    foreach (greet[i]) send_req(ACT_BYTE, greet[i]);
    // reply that never completes
    send_padding(MAX_REPLY_BYTES + 1);
    // same in QUIT ends the exchange as done
    send_req(ACT_START, 8'h00);
    while (ph != PH_QUIT && ph != PH_FINISHED) send_reply(fitting_code(), 1'b0);
    send_padding(MAX_REPLY_BYTES + 1);
    drain_results();
  endtask

  // receiver holds off long enough that the input side stalls
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    configure(SEC_STARTTLS, AUTH_LOGIN, 1'b1, 1'b1);
    stall_cycles = LONG_STALL;
    run_exchange();
    run_exchange();
    // sender pauses here until every result is in
    drain_results();
  endtask

  task automatic test_random_exchanges();
    int round;
    sent  = 0;
    round = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (round % 3 == 0) begin
        case (round / 3)
          0: configure(SEC_STARTTLS, AUTH_LOGIN, 1'b1, 1'b1);
          1: configure(SEC_STARTTLS, AUTH_PLAIN, 1'b1, 1'b0);
          2: configure(SEC_SPARE, AUTH_SPARE, 1'b1, 1'b1);
          3: configure(SEC_STARTTLS, AUTH_NONE, 1'b0, 1'b1);
          4: configure(SEC_PLAIN, AUTH_LOGIN, 1'b0, 1'b1);
          5: configure(SEC_OTHER, AUTH_PLAIN, 1'b1, 1'b1);
          default: configure($urandom_range(0, 1) ? SEC_STARTTLS : 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)), $urandom_range(0, 3) != 0,
                             $urandom_range(0, 3) != 0);
        endcase
      end
      // mostly gaps on both sides, sometimes a clean stretch
      tx_gaps_on = $urandom_range(0, 3) != 0;
      rx_gaps_on = $urandom_range(0, 3) != 0;
      run_exchange();
      round++;
    end
  endtask

  // --------------------------------------------------------------------------
  // clock, result side, checking, watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random hold-off per result, plus the long stall on request
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (stall_cycles > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall_cycles) @(negedge clk);
        stall_cycles = 0;
      end
      gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // each accepted result against the oldest owed one
  always @(posedge clk) begin
    outcome_t owed;
    if (!rst && out_valid && out_ready) begin
      if (outcomes_due.size() == 0) begin
        $error("result with nothing owed: command %0d status %0d code %0d",
               command, status, reply_code);
        errors++;
      end else begin
        owed = outcomes_due.pop_front();
        if (command !== owed.cmd) begin
          $error("command mismatch: expected %0d, got %0d", owed.cmd, command);
          errors++;
        end
        if (status !== owed.stat) begin
          $error("status mismatch: expected %0d, got %0d", owed.stat, status);
          errors++;
        end
        if (reply_code !== owed.code) begin
          $error("reply_code mismatch: expected %0d, got %0d", owed.code, reply_code);
          errors++;
        end
      end
    end
  end

  // no handshake on any channel for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = ACT_START;
    rx_byte      = 8'h00;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_SECURITY_MODE;
    cfg_data     = 2'd0;
    errors       = 0;
    sent         = 0;
    quiet        = 0;
    stall_cycles = 0;
    tx_gaps_on   = 1'b1;
    rx_gaps_on   = 1'b1;
    // register defaults and an idle exchange, as after reset
    cfg_m.security_mode       = SEC_PLAIN;
    cfg_m.auth_mode           = AUTH_NONE;
    cfg_m.credentials_present = 1'b0;
    cfg_m.upgrade_available   = 1'b1;
    ph        = PH_IDLE;
    reply_len = 0;
    restart_line();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_reply_limit();
    test_backpressure();
    test_random_exchanges();

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scs_pkg.sv
rtl/scs_line_scanner.sv
rtl/scs_phase_ctrl.sv
rtl/smtp_client_sequencer.sv
bench/tb_smtp_client_sequencer.sv
